/* design/pet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants of the path expression tokenizer.
// ----------------------------------------------------------------------------
package pet_pkg;

	localparam int PATH_BYTES_DEF = 4096;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// magnitude of the most negative int32; the largest int32 is one below it
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_DOLLAR,
		PH_NAME,
		PH_INDEX,
		PH_CLOSED,
		PH_ERROR
	} pet_phase_t;

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_INDEX = 2'd1,
		KIND_ROOT  = 2'd2,
		KIND_ERROR = 2'd3
	} pet_kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_AFTER_ROOT = 3'd1;
	localparam logic [2:0] ERR_NO_CLOSE  = 3'd2;
	localparam logic [2:0] ERR_BAD_INDEX = 3'd3;
	localparam logic [2:0] ERR_EMPTY     = 3'd4;
	localparam logic [2:0] ERR_BAD_COMP  = 3'd5;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd6;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       final_byte;
	} pet_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        start_offset;
		logic [11:0]        name_length;
		logic signed [31:0] array_index;
		logic [2:0]         error_code;
		logic               path_done;
	} pet_out_t;

endpackage

/* design/pet_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_core
// Tokenizer state and the per-byte decode; result is combinational.
// ----------------------------------------------------------------------------
module pet_core import pet_pkg::*; #(
	parameter int PATH_BYTES = PATH_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  pet_in_t  item,
	output logic     res_valid,
	output pet_out_t res
);

	localparam int POS_W = $clog2(PATH_BYTES + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PATH_BYTES);

	pet_phase_t       phase_q, phase_d;
	logic             in_bracket_q, in_bracket_d;
	logic [POS_W-1:0] name_start_q, name_start_d;
	logic [POS_W-1:0] name_len_q, name_len_d;
	logic [POS_W-1:0] byte_pos_q, byte_pos_d;
	logic [31:0]      mag_q, mag_d;
	logic             neg_q, neg_d;
	logic             bad_q, bad_d;

	function automatic logic [11:0] fit12(input logic [POS_W-1:0] v);
		logic [POS_W+11:0] w;
		w = {12'b0, v};
		return w[11:0];
	endfunction

	logic [7:0]       c;
	logic             fin;
	logic             is_dollar, is_dot, is_lbr, is_rbr, is_minus, is_digit;
	logic             pos_ovf;
	logic [POS_W-1:0] pos_inc, len_inc;
	logic [34:0]      mac;
	logic [31:0]      mac_sat;
	logic             mac_ovf;
	logic             idx_err;
	logic [31:0]      idx_val;

	assign c         = item.path_byte;
	assign fin       = item.final_byte;
	assign is_dollar = (c == CH_DOLLAR);
	assign is_dot    = (c == CH_DOT);
	assign is_lbr    = (c == CH_LBR);
	assign is_rbr    = (c == CH_RBR);
	assign is_minus  = (c == CH_MINUS);
	assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign pos_ovf   = (byte_pos_q >= POS_LIMIT);
	assign pos_inc   = byte_pos_q + 1'b1;
	assign len_inc   = (name_len_q < POS_LIMIT) ? name_len_q + 1'b1 : name_len_q;

	// times ten as two shifts, then clamp to the magnitude of the most negative int32
	assign mac     = ({3'b0, mag_q} << 3) + ({3'b0, mag_q} << 1) + {31'b0, c[3:0]};
	assign mac_ovf = (mac > {3'b0, MAG_LIMIT});
	assign mac_sat = mac_ovf ? MAG_LIMIT : mac[31:0];

	assign idx_err = bad_q || (neg_q ? (mag_q > MAG_LIMIT) : (mag_q >= MAG_LIMIT));
	assign idx_val = neg_q ? (32'd0 - mag_q) : mag_q;

	// next state
	always_comb begin
		logic clr;
		logic to_err;
		clr          = 1'b0;
		to_err       = 1'b0;
		phase_d      = phase_q;
		in_bracket_d = in_bracket_q;
		name_start_d = name_start_q;
		name_len_d   = name_len_q;
		byte_pos_d   = byte_pos_q;
		mag_d        = mag_q;
		neg_d        = neg_q;
		bad_d        = bad_q;
		if (take) begin
			if (phase_q == PH_ERROR) begin
				clr = fin;
			end else if (pos_ovf) begin
				to_err = 1'b1;
			end else begin
				byte_pos_d = pos_inc;
				unique case (phase_q) inside
					PH_FIRST, PH_DOLLAR: begin
						if (phase_q == PH_FIRST && is_dollar) begin
							phase_d = PH_DOLLAR;
							clr     = fin;
						end else if (is_dot) begin
							phase_d      = PH_NAME;
							in_bracket_d = 1'b0;
							name_start_d = pos_inc;
							name_len_d   = '0;
							clr          = fin;
						end else if (is_lbr) begin
							phase_d      = PH_INDEX;
							in_bracket_d = 1'b1;
							name_len_d   = '0;
							mag_d        = '0;
							neg_d        = 1'b0;
							bad_d        = 1'b0;
							clr          = fin;
						end else if (phase_q == PH_DOLLAR) begin
							to_err = 1'b1;
						end else begin
							phase_d      = PH_NAME;
							in_bracket_d = 1'b0;
							name_start_d = byte_pos_q;
							name_len_d   = POS_W'(1);
							clr          = fin;
						end
					end
					PH_NAME: begin
						if (is_dot || is_lbr) begin
							if (name_len_q == '0) begin
								to_err = 1'b1;
							end else if (fin) begin
								clr = 1'b1;
							end else if (is_dot) begin
								name_start_d = pos_inc;
								name_len_d   = '0;
							end else begin
								phase_d      = PH_INDEX;
								in_bracket_d = 1'b1;
								name_len_d   = '0;
								mag_d        = '0;
								neg_d        = 1'b0;
								bad_d        = 1'b0;
							end
						end else begin
							name_len_d = len_inc;
							clr        = fin;
						end
					end
					PH_INDEX: begin
						if (is_rbr) begin
							if (idx_err || name_len_q == '0) begin
								to_err = 1'b1;
							end else begin
								phase_d      = PH_CLOSED;
								in_bracket_d = 1'b0;
								clr          = fin;
							end
						end else if (fin) begin
							clr = 1'b1;
						end else begin
							if (is_minus && name_len_q == '0) begin
								neg_d = 1'b1;
							end else if (is_digit) begin
								mag_d = mac_sat;
								if (mac_ovf)
									bad_d = 1'b1;
							end else begin
								bad_d = 1'b1;
							end
							name_len_d = len_inc;
						end
					end
					PH_CLOSED: begin
						if (is_dot) begin
							phase_d      = PH_NAME;
							in_bracket_d = 1'b0;
							name_start_d = pos_inc;
							name_len_d   = '0;
							clr          = fin;
						end else if (is_lbr) begin
							phase_d      = PH_INDEX;
							in_bracket_d = 1'b1;
							name_len_d   = '0;
							mag_d        = '0;
							neg_d        = 1'b0;
							bad_d        = 1'b0;
							clr          = fin;
						end else begin
							to_err = 1'b1;
						end
					end
					default: clr = 1'b1;
				endcase
			end
			// an error on the last byte ends the path at once
			if (to_err) begin
				if (fin)
					clr = 1'b1;
				else
					phase_d = PH_ERROR;
			end
			if (clr) begin
				phase_d      = PH_FIRST;
				in_bracket_d = 1'b0;
				name_start_d = '0;
				name_len_d   = '0;
				byte_pos_d   = '0;
				mag_d        = '0;
				neg_d        = 1'b0;
				bad_d        = 1'b0;
			end
		end
	end

	// result of the current byte
	always_comb begin
		logic [2:0] err;
		logic       emit_err;
		err       = ERR_NONE;
		emit_err  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		if (phase_q != PH_ERROR) begin
			if (pos_ovf) begin
				emit_err = 1'b1;
				err      = ERR_TOO_LONG;
			end else begin
				unique case (phase_q) inside
					PH_FIRST, PH_DOLLAR: begin
						if ((phase_q == PH_FIRST && is_dollar) || is_dot) begin
							if (fin) begin
								res_valid     = 1'b1;
								res.kind      = KIND_ROOT;
								res.path_done = 1'b1;
							end
						end else if (is_lbr) begin
							emit_err = fin;
							err      = ERR_NO_CLOSE;
						end else if (phase_q == PH_DOLLAR) begin
							emit_err = 1'b1;
							err      = ERR_AFTER_ROOT;
						end else if (fin) begin
							res_valid        = 1'b1;
							res.kind         = KIND_NAME;
							res.start_offset = fit12(byte_pos_q);
							res.name_length  = 12'd1;
							res.path_done    = 1'b1;
						end
					end
					PH_NAME: begin
						if (is_dot || is_lbr) begin
							if (name_len_q == '0) begin
								emit_err = 1'b1;
								err      = ERR_EMPTY;
							end else if (fin) begin
								emit_err = 1'b1;
								err      = is_dot ? ERR_EMPTY : ERR_NO_CLOSE;
							end else begin
								res_valid        = 1'b1;
								res.kind         = KIND_NAME;
								res.start_offset = fit12(name_start_q);
								res.name_length  = fit12(name_len_q);
							end
						end else if (fin) begin
							res_valid        = 1'b1;
							res.kind         = KIND_NAME;
							res.start_offset = fit12(name_start_q);
							res.name_length  = fit12(len_inc);
							res.path_done    = 1'b1;
						end
					end
					PH_INDEX: begin
						if (is_rbr) begin
							if (idx_err) begin
								emit_err = 1'b1;
								err      = ERR_BAD_INDEX;
							end else if (name_len_q == '0) begin
								emit_err = 1'b1;
								err      = ERR_EMPTY;
							end else begin
								res_valid       = 1'b1;
								res.kind        = KIND_INDEX;
								res.array_index = idx_val;
								res.path_done   = fin;
							end
						end else if (fin) begin
							emit_err = 1'b1;
							err      = ERR_NO_CLOSE;
						end
					end
					PH_CLOSED: begin
						if (is_dot) begin
							emit_err = fin;
							err      = ERR_EMPTY;
						end else if (is_lbr) begin
							emit_err = fin;
							err      = ERR_NO_CLOSE;
						end else begin
							emit_err = 1'b1;
							err      = ERR_BAD_COMP;
						end
					end
					default: ;
				endcase
			end
		end
		if (emit_err) begin
			res_valid      = 1'b1;
			res            = '0;
			res.kind       = KIND_ERROR;
			res.error_code = err;
			res.path_done  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			in_bracket_q <= 1'b0;
			name_start_q <= '0;
			name_len_q   <= '0;
			byte_pos_q   <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			bad_q        <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			in_bracket_q <= in_bracket_d;
			name_start_q <= name_start_d;
			name_len_q   <= name_len_d;
			byte_pos_q   <= byte_pos_d;
			mag_q        <= mag_d;
			neg_q        <= neg_d;
			bad_q        <= bad_d;
		end
	end

endmodule

/* design/path_expression_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_expression_tokenizer
// Splits a path expression, one byte a beat, into names, indices, root and
// error tokens.
// ----------------------------------------------------------------------------
//  channel  | direction | payload   | handshake
//  byte     | in        | pet_in_t  | byte_valid / byte_ready
//  token    | out       | pet_out_t | token_valid / token_ready
//
// One byte a cycle while tokens are taken; a token is offered once its byte
// has passed the input register and been decoded into the token register.
// The rate is set by the state update of the decode, one byte per pass.
// Reset clears the tokenizer state and both valid flags; no clearing pass.
// A held token blocks decode of the byte in the input register until it is
// taken, token or not; one more byte can enter, then byte_ready drops.
// ----------------------------------------------------------------------------
module path_expression_tokenizer import pet_pkg::*; #(
	parameter int PATH_BYTES = PATH_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  pet_in_t  byte_data,
	output logic     token_valid,
	input  logic     token_ready,
	output pet_out_t token_data
);

	logic     valid_s1;
	pet_in_t  item_s1;
	logic     out_valid_q;
	pet_out_t out_q;
	logic     adv;
	logic     res_valid;
	pet_out_t res;

	// decode the held byte once the token register can take its result
	assign adv        = valid_s1 && (!out_valid_q || token_ready);
	assign byte_ready = !valid_s1 || adv;

	pet_core #(
		.PATH_BYTES(PATH_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (adv),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && token_ready)
				out_valid_q <= 1'b0;
			if (adv && res_valid)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid)
			out_q <= res;
	end

	assign token_valid = out_valid_q;
	assign token_data  = out_q;

endmodule

/* sim/tb_path_expression_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_expression_tokenizer
// Feeds path expressions to the tokenizer one byte a beat and checks every
// token against a cycle-free model of the tokenizer held in a scoreboard.
// Runs hand-picked paths for the corner cases, then random paths, mostly
// well formed, some damaged or pure noise.
// Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb_path_expression_tokenizer;
	import pet_pkg::*;

	localparam int PATH_LIMIT   = PATH_BYTES_DEF;
	localparam int RANDOM_BYTES = 1270;

	logic     clk;
	logic     arst_n;
	logic     byte_valid;
	logic     byte_ready;
	pet_in_t  byte_data;
	logic     token_valid;
	logic     token_ready;
	pet_out_t token_data;

	// idling controls, changed per path by the stimulus
	bit quiet;
	int gap_pct;
	int stall_pct;

	logic [7:0]  path_q[$];
	int unsigned paths_sent;

	class token_scoreboard;
		pet_phase_t  phase;
		bit          in_bracket;
		int unsigned name_start;
		int unsigned name_len;
		int unsigned byte_pos;
		logic [31:0] idx_mag;
		bit          idx_neg;
		bit          idx_bad;
		pet_out_t    pending_tokens[$];
		int unsigned errors;
		int unsigned tokens_seen;
		int unsigned bytes_seen;

		function new();
			restart();
		endfunction

		function void restart();
			phase      = PH_FIRST;
			in_bracket = 1'b0;
			name_start = 0;
			name_len   = 0;
			byte_pos   = 0;
			idx_mag    = '0;
			idx_neg    = 1'b0;
			idx_bad    = 1'b0;
		endfunction

		function pet_out_t make_token(pet_kind_t k, int unsigned start, int unsigned len,
				logic [31:0] idx, logic [2:0] err, bit done);
			pet_out_t t;
			t.kind         = k;
			t.start_offset = start[11:0];
			t.name_length  = len[11:0];
			t.array_index  = idx;
			t.error_code   = err;
			t.path_done    = done;
			return t;
		endfunction

		function bit fail(output pet_out_t t, input logic [2:0] code, input bit fin);
			t = make_token(KIND_ERROR, 0, 0, '0, code, 1'b1);
			if (fin)
				restart();
			else
				phase = PH_ERROR;
			return 1'b1;
		endfunction

		function bit root(output pet_out_t t);
			t = make_token(KIND_ROOT, 0, 0, '0, ERR_NONE, 1'b1);
			restart();
			return 1'b1;
		endfunction

		function void open_name(int unsigned start);
			phase      = PH_NAME;
			in_bracket = 1'b0;
			name_start = start;
			name_len   = 0;
		endfunction

		function void open_index();
			phase      = PH_INDEX;
			in_bracket = 1'b1;
			name_len   = 0;
			idx_mag    = '0;
			idx_neg    = 1'b0;
			idx_bad    = 1'b0;
		endfunction

		function void take_index_byte(logic [7:0] c);
			longint unsigned m;
			if (c == CH_MINUS && name_len == 0) begin
				idx_neg = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				m = idx_mag;
				m = m * 10 + (c - CH_ZERO);
				// saturate just past int32 range so overflow stays sticky
				if (m > MAG_LIMIT) begin
					idx_bad = 1'b1;
					m = MAG_LIMIT;
				end
				idx_mag = m[31:0];
			end else begin
				idx_bad = 1'b1;
			end
			if (name_len < PATH_LIMIT)
				name_len++;
		endfunction

		function bit close_index(output pet_out_t t, input bit fin);
			logic [31:0] v;
			if (idx_bad)
				return fail(t, ERR_BAD_INDEX, fin);
			if (idx_neg ? (idx_mag > MAG_LIMIT) : (idx_mag > MAG_LIMIT - 1))
				return fail(t, ERR_BAD_INDEX, fin);
			if (name_len == 0)
				return fail(t, ERR_EMPTY, fin);
			v = idx_neg ? (32'd0 - idx_mag) : idx_mag;
			t = make_token(KIND_INDEX, 0, 0, v, ERR_NONE, fin);
			if (fin) begin
				restart();
			end else begin
				phase      = PH_CLOSED;
				in_bracket = 1'b0;
			end
			return 1'b1;
		endfunction

		// advance the tokenizer by one byte; returns 1 when a token is due
		function bit tokenize_byte(input pet_in_t b, output pet_out_t t);
			logic [7:0]  c;
			bit          fin;
			int unsigned pos;
			c   = b.path_byte;
			fin = b.final_byte;
			pos = byte_pos;
			t   = '0;
			if (phase == PH_ERROR) begin
				if (fin)
					restart();
				return 1'b0;
			end
			if (pos >= PATH_LIMIT)
				return fail(t, ERR_TOO_LONG, fin);
			byte_pos = pos + 1;
			case (phase) inside
				PH_FIRST, PH_DOLLAR: begin
					if (phase == PH_FIRST && c == CH_DOLLAR) begin
						if (fin)
							return root(t);
						phase = PH_DOLLAR;
						return 1'b0;
					end
					if (c == CH_DOT) begin
						if (fin)
							return root(t);
						open_name(pos + 1);
						return 1'b0;
					end
					if (c == CH_LBR) begin
						if (fin)
							return fail(t, ERR_NO_CLOSE, fin);
						open_index();
						return 1'b0;
					end
					if (phase == PH_DOLLAR)
						return fail(t, ERR_AFTER_ROOT, fin);
					open_name(pos);
					name_len = 1;
					if (fin) begin
						t = make_token(KIND_NAME, name_start, name_len, '0, ERR_NONE, 1'b1);
						restart();
						return 1'b1;
					end
					return 1'b0;
				end
				PH_NAME: begin
					if (c == CH_DOT || c == CH_LBR) begin
						if (name_len == 0)
							return fail(t, ERR_EMPTY, fin);
						// delimiter as last byte: the error wins, the name is lost
						if (fin)
							return fail(t, (c == CH_DOT) ? ERR_EMPTY : ERR_NO_CLOSE, fin);
						t = make_token(KIND_NAME, name_start, name_len, '0, ERR_NONE, 1'b0);
						if (c == CH_DOT)
							open_name(pos + 1);
						else
							open_index();
						return 1'b1;
					end
					if (name_len < PATH_LIMIT)
						name_len++;
					if (fin) begin
						t = make_token(KIND_NAME, name_start, name_len, '0, ERR_NONE, 1'b1);
						restart();
						return 1'b1;
					end
					return 1'b0;
				end
				PH_INDEX: begin
					if (c == CH_RBR)
						return close_index(t, fin);
					if (fin)
						return fail(t, ERR_NO_CLOSE, fin);
					take_index_byte(c);
					return 1'b0;
				end
				PH_CLOSED: begin
					if (c == CH_DOT) begin
						if (fin)
							return fail(t, ERR_EMPTY, fin);
						open_name(pos + 1);
						return 1'b0;
					end
					if (c == CH_LBR) begin
						if (fin)
							return fail(t, ERR_NO_CLOSE, fin);
						open_index();
						return 1'b0;
					end
					return fail(t, ERR_BAD_COMP, fin);
				end
				default: begin
					restart();
					return 1'b0;
				end
			endcase
		endfunction

		function void note_byte(pet_in_t b);
			pet_out_t t;
			bytes_seen++;
			if (tokenize_byte(b, t))
				pending_tokens.push_back(t);
		endfunction

		function string show(pet_out_t t);
			return $sformatf("kind=%0d off=%0d len=%0d idx=%0d err=%0d done=%0d",
				t.kind, t.start_offset, t.name_length, t.array_index, t.error_code,
				t.path_done);
		endfunction

		function void report(string what, pet_out_t exp, pet_out_t got);
			errors++;
			if (errors <= 10)
				$display("%0t %s: exp %s / got %s", $realtime, what, show(exp), show(got));
		endfunction

		function void check_token(pet_out_t got);
			pet_out_t exp;
			tokens_seen++;
			if (pending_tokens.size() == 0) begin
				report("token with none expected", '0, got);
				return;
			end
			exp = pending_tokens.pop_front();
			if (got.kind !== exp.kind || got.start_offset !== exp.start_offset ||
					got.name_length !== exp.name_length ||
					got.array_index !== exp.array_index ||
					got.error_code !== exp.error_code || got.path_done !== exp.path_done)
				report("token mismatch", exp, got);
		endfunction
	endclass

	token_scoreboard sb = new();

	path_expression_tokenizer #(.PATH_BYTES(PATH_LIMIT)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_data (token_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && token_valid && token_ready)
			sb.check_token(token_data);
	end

	initial begin
		token_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				token_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			token_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] c, input bit last);
		pet_in_t b;
		b.path_byte  = c;
		b.final_byte = last;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= b;
		do @(posedge clk); while (!byte_ready);
		sb.note_byte(b);
	endtask

	task automatic send_path();
		for (int i = 0; i < path_q.size(); i++)
			send_byte(path_q[i], i == path_q.size() - 1);
		paths_sent++;
	endtask

	task automatic send_text(string s);
		path_q.delete();
		for (int i = 0; i < s.len(); i++)
			path_q.push_back(s[i]);
		send_path();
	endtask

	function automatic int pick_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_DOT || c == CH_LBR);
		return c;
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 6))
			0: return CH_DOLLAR;
			1: return CH_DOT;
			2: return CH_LBR;
			3: return CH_RBR;
			4: return CH_MINUS;
			5: return 8'(CH_ZERO + $urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic string index_text();
		longint unsigned v;
		string           s;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 9);
			1: v = $urandom_range(0, 99999);
			2: v = $urandom;
			3: v = 64'd2147483647 + $urandom_range(0, 2);
			4: v = {$urandom, $urandom} % 64'd100000000000000;
			5: return "";
			6: return "-";
			default: v = $urandom_range(0, 1000);
		endcase
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 7) == 0)
			s = {"0", s};
		if ($urandom_range(0, 2) == 0)
			s = {"-", s};
		return s;
	endfunction

	// mostly well formed paths with random names and indices; a fifth damaged
	task automatic make_path();
		int    n;
		int    k;
		bit    dollar;
		bit    dot;
		string s;
		path_q.delete();
		if ($urandom_range(0, 19) == 0) begin
			case ($urandom_range(0, 2))
				0: path_q = '{CH_DOLLAR};
				1: path_q = '{CH_DOLLAR, CH_DOT};
				default: path_q = '{CH_DOT};
			endcase
			return;
		end
		dollar = ($urandom_range(0, 4) == 0);
		dot    = !dollar && ($urandom_range(0, 4) == 0);
		if (dollar)
			path_q.push_back(CH_DOLLAR);
		if (dot)
			path_q.push_back(CH_DOT);
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			if (!(dot && i == 0) && $urandom_range(0, 2) == 0) begin
				s = index_text();
				path_q.push_back(CH_LBR);
				for (int j = 0; j < s.len(); j++)
					path_q.push_back(s[j]);
				path_q.push_back(CH_RBR);
			end else begin
				if (i > 0 || dollar)
					path_q.push_back(CH_DOT);
				repeat ($urandom_range(1, 6)) path_q.push_back(name_char());
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, path_q.size() - 1);
			case ($urandom_range(0, 3))
				0: path_q[k] = 8'($urandom_range(0, 255));
				1: path_q.insert(k, special_char());
				2: while (path_q.size() > k + 1) void'(path_q.pop_back());
				default: begin
					path_q.delete();
					repeat ($urandom_range(1, 8)) path_q.push_back(special_char());
				end
			endcase
		end
	endtask

	initial begin
		#10_000_000;
		$display("tb_path_expression_tokenizer: FAIL");
		$finish;
	end

	initial begin
		string       directed[$];
		int unsigned rand_bytes;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_data  = '0;
		quiet      = 1'b0;
		gap_pct    = 25;
		stall_pct  = 25;
		paths_sent = 0;
		rand_bytes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{"$", "$.", ".", "[", "$x", "a.b", ".ab", "[-2147483648]",
			"[2147483647]", "[2147483648]", "[-2147483649]", "[99999999999]", "[]",
			"[-]", "[1-]", "[--1]", "[12x]", "a..b", "a.", "b[", "[1", "[1]x",
			"[1].", "[1][", "$[3].q", "x[-7]"};
		foreach (directed[i])
			send_text(directed[i]);

		while (rand_bytes < RANDOM_BYTES) begin
			quiet     = (rand_bytes > RANDOM_BYTES * 85 / 100);
			gap_pct   = pick_rate();
			stall_pct = pick_rate();
			make_path();
			send_path();
			rand_bytes += path_q.size();
		end
		byte_valid <= 1'b0;
		quiet = 1'b1;

		while (sb.pending_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d paths, %0d bytes, %0d tokens checked, %0d mismatches",
			paths_sent, sb.bytes_seen, sb.tokens_seen, sb.errors);
		if (sb.errors == 0 && sb.pending_tokens.size() == 0)
			$display("tb_path_expression_tokenizer: PASS");
		else
			$display("tb_path_expression_tokenizer: FAIL");
		$finish;
	end

endmodule
